[rtl/core/tplm_pkg.sv]
// Package of shared types, command codes and status codes for the threshold profile list manager.
package tplm_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 16;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_ERASE  = 3'd1,
    FN_SELECT = 3'd2,
    FN_STEP   = 3'd3,
    FN_RELOAD = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NOCUR    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ACTIVE    = 2'd0,
    CFG_WALL_CIRC = 2'd1,
    CFG_LINE_CIRC = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPLY,
    S_OUT
  } state_t;

endpackage

[rtl/core/threshold_profile_list_manager.sv]
// Top level of the threshold profile list manager: pool storage, cell chain and command sequencer.
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_func, in_list_sel, in_thresh_a/b/c
//   out     | output    | out_valid / out_ready| out_status, out_load_dac, out_a/b/c
//   cfg     | input     | cfg_we               | cfg_idx, cfg_data
// Add, step, reload and unused codes go from acceptance through S_APPLY to the result in S_OUT.
// Erase and select pass a token down a chain of POOL_ENTRIES cells, one per cycle,
// while the sequencer waits in S_WALK; the chain length sets how long the walk lasts.
// Reset is synchronous and restores the free list in index order at once.
// One item is worked at a time; a stalled result holds the block until taken.
module threshold_profile_list_manager #(
  parameter int unsigned POOL_ENTRIES = tplm_pkg::POOL_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic       in_list_sel,
  input  logic [7:0] in_thresh_a,
  input  logic [7:0] in_thresh_b,
  input  logic [7:0] in_thresh_c,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_load_dac,
  output logic [7:0] out_a,
  output logic [7:0] out_b,
  output logic [7:0] out_c,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic       cfg_data
);

  localparam int unsigned IW = $clog2(POOL_ENTRIES + 1);
  localparam logic [IW-1:0] NONE = IW'(POOL_ENTRIES);
  localparam int unsigned AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  tplm_pkg::state_t state_r, state_nxt;

  logic [23:0]   val_r  [POOL_ENTRIES];
  logic [IW-1:0] link_r [POOL_ENTRIES];
  logic [IW-1:0] free_r;
  logic [IW-1:0] head_r [2];
  logic [IW-1:0] tail_r [2];
  logic [IW-1:0] cur_r  [2];
  logic          act_r, wcirc_r, lcirc_r;

  logic [2:0]    func_r;
  logic          lst_r;
  logic [23:0]   key_r;
  logic [IW-1:0] cnt_r;
  logic          found_r;
  logic [IW-1:0] fidx_r, fprev_r;

  logic [1:0]    ost_r;
  logic          oload_r;
  logic [23:0]   oval_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      wcirc_r <= 1'b0;
      lcirc_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tplm_pkg::CFG_ACTIVE:    act_r <= cfg_data;
        tplm_pkg::CFG_WALL_CIRC: wcirc_r <= cfg_data;
        tplm_pkg::CFG_LINE_CIRC: lcirc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic vld(input logic [IW-1:0] i);
    return i < NONE;
  endfunction

  // Cell chain: cell k sees the token and compares it against the entry it names.
  logic          tv [POOL_ENTRIES+1];
  logic [IW-1:0] ti [POOL_ENTRIES+1];
  logic [IW-1:0] tp [POOL_ENTRIES+1];
  logic          th [POOL_ENTRIES+1];
  logic          start;

  assign start = (state_r == tplm_pkg::S_IDLE) && in_valid && in_ready &&
                 (in_func == tplm_pkg::FN_ERASE || in_func == tplm_pkg::FN_SELECT);
  assign tv[0] = start && vld(head_r[in_list_sel]);
  assign ti[0] = head_r[in_list_sel];
  assign tp[0] = NONE;
  assign th[0] = 1'b0;

  logic [23:0] keyw;
  assign keyw = (state_r == tplm_pkg::S_IDLE) ? {in_thresh_c, in_thresh_b, in_thresh_a} : key_r;

  for (genvar k = 0; k < POOL_ENTRIES; k++) begin : g_cell
    logic [AW-1:0] a;
    logic          ok;
    assign ok = vld(ti[k]);
    assign a  = ok ? ti[k][AW-1:0] : '0;
    // The first cell takes the new token on the start edge, so only later cells clear there.
    tplm_cell #(.IW(IW)) u_cell (
      .clk, .rst_n, .clr(start && (k != 0)),
      .tok_vld_i(k == 0 ? tv[0] : tv[k]),
      .tok_idx_i(ti[k]), .tok_prev_i(tp[k]), .tok_hit_i(th[k]),
      .key(keyw), .entry_val(val_r[a]), .entry_link(link_r[a]),
      .idx_ok(ok), .link_ok(vld(link_r[a])),
      .tok_vld_o(tv[k+1]), .tok_idx_o(ti[k+1]),
      .tok_prev_o(tp[k+1]), .tok_hit_o(th[k+1])
    );
  end

  // Token result collected as it leaves any cell with a hit.
  logic          hit_any;
  logic [IW-1:0] hit_idx, hit_prev;
  always_comb begin
    hit_any = 1'b0;
    hit_idx = NONE;
    hit_prev = NONE;
    for (int k = 1; k <= POOL_ENTRIES; k++) begin
      if (tv[k] && th[k]) begin
        hit_any = 1'b1;
        hit_idx = ti[k];
        hit_prev = tp[k];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tplm_pkg::S_IDLE:
        if (in_valid) begin
          state_nxt = (in_func == tplm_pkg::FN_ERASE || in_func == tplm_pkg::FN_SELECT)
                    ? tplm_pkg::S_WALK : tplm_pkg::S_APPLY;
        end
      tplm_pkg::S_WALK:
        if (cnt_r == NONE) state_nxt = tplm_pkg::S_APPLY;
      tplm_pkg::S_APPLY: state_nxt = tplm_pkg::S_OUT;
      tplm_pkg::S_OUT:   if (out_ready) state_nxt = tplm_pkg::S_IDLE;
      default:           state_nxt = tplm_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == tplm_pkg::S_IDLE);
    out_valid = (state_r == tplm_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tplm_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Capture the command, the walk count and the search result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      found_r <= 1'b0;
    end else if (state_r == tplm_pkg::S_IDLE && in_valid) begin
      func_r <= in_func;
      lst_r  <= in_list_sel;
      key_r  <= {in_thresh_c, in_thresh_b, in_thresh_a};
      cnt_r  <= '0;
      found_r <= 1'b0;
    end else if (state_r == tplm_pkg::S_WALK) begin
      cnt_r <= cnt_r + 1'b1;
      if (hit_any && !found_r) begin
        found_r <= 1'b1;
        fidx_r  <= hit_idx;
        fprev_r <= hit_prev;
      end
    end
  end

  // Command execution on the pool and the list pointers.
  always_ff @(posedge clk) begin
    logic [IW-1:0] p, nx, c, nh, nt;
    logic          circ;
    if (!rst_n) begin
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        val_r[i]  <= '0;
        link_r[i] <= IW'(i + 1);
      end
      free_r <= '0;
      for (int l = 0; l < 2; l++) begin
        head_r[l] <= NONE;
        tail_r[l] <= NONE;
        cur_r[l]  <= NONE;
      end
      ost_r <= tplm_pkg::ST_OK;
      oload_r <= 1'b0;
      oval_r <= '0;
    end else if (state_r == tplm_pkg::S_APPLY) begin
      ost_r   <= tplm_pkg::ST_OK;
      oload_r <= 1'b0;
      oval_r  <= '0;
      case (func_r)
        tplm_pkg::FN_ADD: begin
          p = free_r;
          if (!vld(p)) begin
            ost_r <= tplm_pkg::ST_FULL;
          end else begin
            nx = link_r[p[AW-1:0]];
            free_r <= vld(nx) ? nx : NONE;
            val_r[p[AW-1:0]]  <= key_r;
            link_r[p[AW-1:0]] <= NONE;
            if (!vld(head_r[lst_r]) || !vld(tail_r[lst_r])) begin
              head_r[lst_r] <= p;
              cur_r[lst_r]  <= p;
            end else begin
              link_r[tail_r[lst_r][AW-1:0]] <= p;
            end
            tail_r[lst_r] <= p;
          end
        end
        tplm_pkg::FN_ERASE: begin
          if (!found_r) begin
            ost_r <= tplm_pkg::ST_NOTFOUND;
          end else begin
            p  = fidx_r;
            nx = vld(link_r[p[AW-1:0]]) ? link_r[p[AW-1:0]] : NONE;
            nh = head_r[lst_r];
            nt = tail_r[lst_r];
            if (vld(fprev_r)) link_r[fprev_r[AW-1:0]] <= nx;
            else nh = nx;
            if (nt == p) nt = fprev_r;
            circ = lst_r ? lcirc_r : wcirc_r;
            if (!vld(nh)) begin
              nt = NONE;
              cur_r[lst_r] <= NONE;
            end else if (cur_r[lst_r] == p) begin
              c = nx;
              if (!vld(c) && circ) c = nh;
              cur_r[lst_r] <= c;
            end
            head_r[lst_r] <= nh;
            tail_r[lst_r] <= nt;
            val_r[p[AW-1:0]]  <= '0;
            link_r[p[AW-1:0]] <= free_r;
            free_r <= p;
          end
        end
        tplm_pkg::FN_SELECT: begin
          if (!found_r) begin
            ost_r <= tplm_pkg::ST_NOTFOUND;
          end else begin
            cur_r[lst_r] <= fidx_r;
            if (lst_r == act_r) begin
              oload_r <= 1'b1;
              oval_r  <= val_r[fidx_r[AW-1:0]];
            end
          end
        end
        tplm_pkg::FN_STEP: begin
          c = cur_r[act_r];
          circ = act_r ? lcirc_r : wcirc_r;
          if (!vld(c)) begin
            ost_r <= tplm_pkg::ST_NOCUR;
          end else begin
            c = link_r[c[AW-1:0]];
            if (!vld(c)) c = circ ? head_r[act_r] : NONE;
            if (!vld(c)) c = NONE;
            cur_r[act_r] <= c;
            if (vld(c)) begin
              oload_r <= 1'b1;
              oval_r  <= val_r[c[AW-1:0]];
            end else begin
              ost_r <= tplm_pkg::ST_NOCUR;
            end
          end
        end
        tplm_pkg::FN_RELOAD: begin
          c = cur_r[act_r];
          if (vld(c)) begin
            oload_r <= 1'b1;
            oval_r  <= val_r[c[AW-1:0]];
          end else begin
            ost_r <= tplm_pkg::ST_NOCUR;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_status   = ost_r;
  assign out_load_dac = oload_r;
  assign out_a = oval_r[7:0];
  assign out_b = oval_r[15:8];
  assign out_c = oval_r[23:16];

  // A result stays offered until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  // No item is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  // A load never comes with a failing status.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_dac |-> out_status == tplm_pkg::ST_OK)
    else $error("load with bad status");

endmodule

[rtl/core/tplm_cell.sv]
// One pool cell of the search chain: compares the passing token against its entry and forwards it.
module tplm_cell #(
  parameter int unsigned IW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          tok_vld_i,
  input  logic [IW-1:0] tok_idx_i,
  input  logic [IW-1:0] tok_prev_i,
  input  logic          tok_hit_i,
  input  logic [23:0]   key,
  input  logic [23:0]   entry_val,
  input  logic [IW-1:0] entry_link,
  input  logic          idx_ok,
  input  logic          link_ok,
  output logic          tok_vld_o,
  output logic [IW-1:0] tok_idx_o,
  output logic [IW-1:0] tok_prev_o,
  output logic          tok_hit_o
);

  logic          vld_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] prev_r;
  logic          hit_r;

  // A live token is marked hit on a match or moves on to the successor; a hit token passes on unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= 1'b0;
      hit_r <= 1'b0;
      if (tok_vld_i && !tok_hit_i && idx_ok) begin
        if (entry_val == key) begin
          hit_r <= 1'b1;
          vld_r <= 1'b1;
          idx_r <= tok_idx_i;
          prev_r <= tok_prev_i;
        end else if (link_ok) begin
          vld_r <= 1'b1;
          idx_r <= entry_link;
          prev_r <= tok_idx_i;
        end
      end else if (tok_vld_i && tok_hit_i) begin
        hit_r <= 1'b1;
        vld_r <= 1'b1;
        idx_r <= tok_idx_i;
        prev_r <= tok_prev_i;
      end
    end
  end

  assign tok_vld_o  = vld_r;
  assign tok_idx_o  = idx_r;
  assign tok_prev_o = prev_r;
  assign tok_hit_o  = hit_r;

endmodule
